[hw/rtl/roi_rs_pkg.sv]
// Shared types and constants for the ROI reflection shrink block.
// Holds the pixel and result transaction structs and the register map.
// No dependencies.
package roi_rs_pkg;

    localparam int DIM_W  = 10;
    localparam int LUMA_W = 8;

    // Largest region dimension; results wrap at this size.
    localparam int MAX_DIM = 1024;
    localparam logic [DIM_W-1:0] DIM_MASK = DIM_W'(MAX_DIM - 1);

    localparam logic [LUMA_W-1:0] BRIGHT_THRESHOLD_RST = 8'd230;
    localparam logic [DIM_W-1:0]  NEAR_WIDTH_LIMIT_RST = 10'd100;

    localparam int PADDR_W = 3;

    typedef enum logic {
        REG_BRIGHT_THRESHOLD = 1'b0,
        REG_NEAR_WIDTH_LIMIT = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [LUMA_W-1:0] luma;
        logic [DIM_W-1:0]  col_index;
        logic [DIM_W-1:0]  row_index;
        logic [DIM_W-1:0]  region_width;
        logic [DIM_W-1:0]  region_height;
        logic              last_pixel;
    } pixel_t;

    typedef struct packed {
        logic [DIM_W-1:0] new_height;
        logic             tightened;
        logic             scanned;
    } result_t;

endpackage

[hw/rtl/roi_reflection_shrink_top.sv]
// A region's last pixel passes the input register, then its result the result register.
// Throughput: one pixel per cycle, but a last pixel stalls while the result register is
// full and m_ready is low; the input register and the scan state update in one pass, and
// the result register holds a region result while the next region's pixels flow in.
// Reset (aresetn, synchronous, active low) restores the configuration registers, empties
// both registers and closes the region. Top level of the ROI reflection shrink block:
// APB configuration, pixel scans and the height decision. Depends on roi_rs_pkg.
module roi_reflection_shrink_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  roi_rs_pkg::pixel_t                 s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output roi_rs_pkg::result_t                m_data,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [roi_rs_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import roi_rs_pkg::*;

    logic [LUMA_W-1:0] bright_threshold_reg;
    logic [DIM_W-1:0]  near_width_limit_reg;
    reg_index_t        reg_sel;
    logic              cfg_write;

    pixel_t            in_data_reg;
    logic              in_valid_reg;
    logic              advance;

    logic              region_open_reg;
    logic [DIM_W-1:0]  left_col_reg, left_col_next;
    logic [DIM_W-1:0]  left_row_reg, left_row_next;
    logic [DIM_W-1:0]  top_col_reg, top_col_next;
    logic [DIM_W-1:0]  top_row_reg, top_row_next;
    logic              top_found_reg, top_found_next;

    result_t           out_data_reg, out_data_next;
    logic              out_valid_reg;

    logic [DIM_W-1:0]  w, h;
    logic [DIM_W-1:0]  lc, lr, tc, tr;
    logic              tf;
    logic              bright, in_window;
    logic [DIM_W-1:0]  col_gap, row_gap;
    logic              tight_ok;

    // configuration port
    assign pready    = 1'b1;
    assign reg_sel   = reg_index_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bright_threshold_reg <= BRIGHT_THRESHOLD_RST;
            near_width_limit_reg <= NEAR_WIDTH_LIMIT_RST;
        end else if (cfg_write) begin
            case (reg_sel)
                REG_BRIGHT_THRESHOLD: bright_threshold_reg <= pwdata[LUMA_W-1:0];
                REG_NEAR_WIDTH_LIMIT: near_width_limit_reg <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_BRIGHT_THRESHOLD: prdata = {{(32-LUMA_W){1'b0}}, bright_threshold_reg};
            REG_NEAR_WIDTH_LIMIT: prdata = {{(32-DIM_W){1'b0}}, near_width_limit_reg};
            default:              prdata = '0;
        endcase
    end

    // handshake: a pixel leaves the input register unless it must load a full result slot that is not being taken
    assign advance = in_valid_reg &&
                     (!in_data_reg.last_pixel || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    // scan update
    assign w = in_data_reg.region_width;
    assign h = (in_data_reg.region_height > w) ? w : in_data_reg.region_height;

    always_comb begin
        if (region_open_reg) begin
            lc = left_col_reg;
            lr = left_row_reg;
            tc = top_col_reg;
            tr = top_row_reg;
            tf = top_found_reg;
        end else begin
            lc = w;
            lr = '0;
            tc = '0;
            tr = h;
            tf = 1'b0;
        end
    end

    assign bright    = in_data_reg.luma > bright_threshold_reg;
    assign in_window = bright && (in_data_reg.row_index < (h >> 1));

    always_comb begin
        left_col_next  = lc;
        left_row_next  = lr;
        top_col_next   = tc;
        top_row_next   = tr;
        top_found_next = tf;
        if (in_window && in_data_reg.col_index < (w >> 1)) begin
            if (in_data_reg.col_index < lc) begin
                left_col_next = in_data_reg.col_index;
                left_row_next = in_data_reg.row_index;
            end else if (in_data_reg.col_index == lc && in_data_reg.row_index > lr) begin
                left_row_next = in_data_reg.row_index;
            end
        end
        if (in_window && in_data_reg.col_index < w) begin
            if (!tf || in_data_reg.row_index < tr) begin
                top_row_next   = in_data_reg.row_index;
                top_col_next   = in_data_reg.col_index;
                top_found_next = 1'b1;
            end else if (in_data_reg.row_index == tr && in_data_reg.col_index > tc) begin
                top_col_next = in_data_reg.col_index;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_open_reg <= 1'b0;
        end else if (advance) begin
            region_open_reg <= !in_data_reg.last_pixel;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            left_col_reg  <= left_col_next;
            left_row_reg  <= left_row_next;
            top_col_reg   <= top_col_next;
            top_row_reg   <= top_row_next;
            top_found_reg <= top_found_next;
        end
    end

    // height decision
    assign col_gap  = top_col_next - left_col_next;
    assign row_gap  = left_row_next - top_row_next;
    assign tight_ok = (left_col_next < top_col_next) &&
                      (top_row_next < left_row_next) &&
                      ({col_gap, 1'b0} < {1'b0, w}) &&
                      ({row_gap, 1'b0} < {1'b0, h});

    always_comb begin
        out_data_next.scanned    = w <= near_width_limit_reg;
        out_data_next.tightened  = out_data_next.scanned && tight_ok;
        out_data_next.new_height = out_data_next.tightened ?
                                   ({row_gap[DIM_W-2:0], 1'b0} & DIM_MASK) :
                                   (h & DIM_MASK);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_data_reg.last_pixel) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_data_reg.last_pixel) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

[tb/sv/roi_reflection_shrink_top_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for roi_reflection_shrink_top: streams region pixels, writes the
// threshold and width limit over APB, and checks every height result against a local model
// or a directed expected value. Depends on roi_rs_pkg and roi_reflection_shrink_top.
module roi_reflection_shrink_top_tb;
    import roi_rs_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_CYCLES = 6;
    localparam int STALL_LIMIT  = 4000;
    localparam int SHOWN_ERRORS = 10;
    localparam int PHASE_PIXELS = 50;
    localparam int PHASE_HEIGHTS = 3;
    localparam int PIX_W = $bits(pixel_t);

    typedef struct packed {
        pixel_t  px;
        logic    typed;
        result_t want;
    } stim_row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    pixel_t             s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    result_t            m_data;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    logic [LUMA_W-1:0]  thr_q = BRIGHT_THRESHOLD_RST;
    logic [DIM_W-1:0]   limit_q = NEAR_WIDTH_LIMIT_RST;
    logic [DIM_W-1:0]   left_col_q = '0;
    logic [DIM_W-1:0]   left_row_q = '0;
    logic [DIM_W-1:0]   top_col_q = '0;
    logic [DIM_W-1:0]   top_row_q = '0;
    logic               top_found_q = 1'b0;
    logic               region_open_q = 1'b0;

    result_t            pending_heights[$];
    stim_row_t          dir_table[$];
    int                 height_errors = 0;
    int                 src_idle_pct = 0;
    int                 sink_idle_pct = 0;
    int                 phase_pixels = 0;
    int                 phase_results = 0;
    int                 stall_cycles = 0;

    roi_reflection_shrink_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic bit predict_height(input pixel_t px, output result_t res);
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        w = px.region_width;
        h = (px.region_height > w) ? w : px.region_height;
        res = '0;
        if (!region_open_q) begin
            left_col_q = w;
            left_row_q = '0;
            top_col_q = '0;
            top_row_q = h;
            top_found_q = 1'b0;
            region_open_q = 1'b1;
        end
        if (px.luma > thr_q && px.row_index < h / 2) begin
            if (px.col_index < w / 2) begin
                if (px.col_index < left_col_q) begin
                    left_col_q = px.col_index;
                    left_row_q = px.row_index;
                end else if (px.col_index == left_col_q && px.row_index > left_row_q) begin
                    left_row_q = px.row_index;
                end
            end
            if (px.col_index < w) begin
                if (!top_found_q || px.row_index < top_row_q) begin
                    top_row_q = px.row_index;
                    top_col_q = px.col_index;
                    top_found_q = 1'b1;
                end else if (px.row_index == top_row_q && px.col_index > top_col_q) begin
                    top_col_q = px.col_index;
                end
            end
        end
        if (!px.last_pixel)
            return 1'b0;
        region_open_q = 1'b0;
        res.new_height = h;
        if (w <= limit_q) begin
            res.scanned = 1'b1;
            if (left_col_q < top_col_q && top_row_q < left_row_q
                    && 2 * (int'(top_col_q) - int'(left_col_q)) < int'(w)
                    && 2 * (int'(left_row_q) - int'(top_row_q)) < int'(h)) begin
                res.new_height = DIM_W'(2 * (int'(left_row_q) - int'(top_row_q)));
                res.tightened = 1'b1;
            end
        end
        return 1'b1;
    endfunction

    function automatic stim_row_t mk_row(input int luma, input int col, input int row,
                                         input int w, input int h, input int last,
                                         input bit typed = 1'b0, input int nh = 0,
                                         input int tight = 0, input int scan = 0);
        stim_row_t r;
        r.px.luma = LUMA_W'(luma);
        r.px.col_index = DIM_W'(col);
        r.px.row_index = DIM_W'(row);
        r.px.region_width = DIM_W'(w);
        r.px.region_height = DIM_W'(h);
        r.px.last_pixel = last[0];
        r.typed = typed;
        r.want.new_height = DIM_W'(nh);
        r.want.tightened = tight[0];
        r.want.scanned = scan[0];
        return r;
    endfunction

    function automatic logic [LUMA_W-1:0] pick_luma(input int bright_pct);
        int t;
        t = thr_q;
        if ($urandom_range(99) < bright_pct)
            return (t < 255) ? LUMA_W'($urandom_range(255, t + 1)) : 8'hFF;
        return LUMA_W'($urandom_range(t, 0));
    endfunction

    task automatic note_error(input string tag, input result_t want, input result_t got);
        height_errors++;
        if (height_errors <= SHOWN_ERRORS)
            $display("%0t %s: expected h=%0d t=%0d s=%0d, got h=%0d t=%0d s=%0d", $time, tag,
                     want.new_height, want.tightened, want.scanned,
                     got.new_height, got.tightened, got.scanned);
    endtask

    task automatic drive_pixel(input pixel_t px, input bit typed, input result_t want);
        result_t res;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= px;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        phase_pixels++;
        if (predict_height(px, res)) begin
            pending_heights.push_back(typed ? want : res);
            phase_results++;
        end
    endtask

    task automatic write_config(input logic [LUMA_W-1:0] thr, input logic [DIM_W-1:0] lim);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_BRIGHT_THRESHOLD, 2'b00};
        pwdata <= {24'($urandom), thr};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        penable <= 1'b0;
        paddr <= {REG_NEAR_WIDTH_LIMIT, 2'b00};
        pwdata <= {22'($urandom), lim};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        thr_q = thr;
        limit_q = lim;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (pending_heights.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic send_region();
        pixel_t px;
        int w;
        int h;
        int rows;
        int dens;
        w = $urandom_range(10, 2);
        h = ($urandom_range(9) == 0) ? $urandom_range(1023, 1) : $urandom_range(14, 1);
        rows = (h < 8) ? h : 8;
        dens = $urandom_range(40, 5);
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < w; c++) begin
                px.luma = pick_luma(dens);
                px.col_index = DIM_W'(c);
                px.row_index = DIM_W'(r);
                px.region_width = DIM_W'(w);
                px.region_height = DIM_W'(h);
                px.last_pixel = (r == rows - 1 && c == w - 1);
                drive_pixel(px, 1'b0, '0);
            end
        end
    endtask

    task automatic send_fragment();
        pixel_t px;
        int n;
        n = $urandom_range(6, 1);
        px.region_width = DIM_W'($urandom);
        px.region_height = DIM_W'($urandom);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 20)
                px.region_width = DIM_W'($urandom);
            px.luma = pick_luma(50);
            px.col_index = ($urandom_range(99) < 70) ?
                           DIM_W'($urandom_range(px.region_width)) : DIM_W'($urandom);
            px.row_index = ($urandom_range(99) < 70) ?
                           DIM_W'($urandom_range(px.region_height)) : DIM_W'($urandom);
            px.last_pixel = (k == n - 1);
            drive_pixel(px, 1'b0, '0);
        end
    endtask

    always @(posedge aclk) begin : result_check
        result_t want;
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        if (aresetn && m_valid && m_ready) begin
            if (pending_heights.size() == 0) begin
                note_error("unexpected transaction", '0, m_data);
            end else begin
                want = pending_heights.pop_front();
                if (m_data.new_height !== want.new_height || m_data.tightened !== want.tightened
                        || m_data.scanned !== want.scanned)
                    note_error("mismatch", want, m_data);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        pixel_t px;
        int pick;
        // reset values
        dir_table.push_back(mk_row(255, 0, 0, 1, 1, 1, 1'b1, 1, 0, 1));
        dir_table.push_back(mk_row(255, 0, 0, 0, 0, 1, 1'b1, 0, 0, 1));
        dir_table.push_back(mk_row(255, 1023, 1023, 1023, 1023, 1, 1'b1, 1023, 0, 0));
        dir_table.push_back(mk_row(0, 0, 0, 5, 1023, 1, 1'b1, 5, 0, 1));
        dir_table.push_back(mk_row(255, 0, 0, 101, 50, 1, 1'b1, 50, 0, 0));
        // tighten: threshold edge, same-column and same-row updates, out-of-window pixels
        dir_table.push_back(mk_row(230, 2, 0, 16, 16, 0));
        dir_table.push_back(mk_row(231, 3, 0, 16, 16, 0));
        dir_table.push_back(mk_row(255, 1, 2, 16, 16, 0));
        dir_table.push_back(mk_row(255, 1, 3, 16, 16, 0));
        dir_table.push_back(mk_row(255, 5, 0, 16, 16, 0));
        dir_table.push_back(mk_row(255, 12, 1, 16, 16, 0));
        dir_table.push_back(mk_row(255, 2, 9, 16, 16, 0));
        dir_table.push_back(mk_row(0, 15, 15, 16, 16, 1));
        // sizes change inside the region, pixels out of order
        dir_table.push_back(mk_row(255, 6, 5, 20, 30, 0));
        dir_table.push_back(mk_row(255, 8, 2, 20, 30, 0));
        dir_table.push_back(mk_row(255, 4, 7, 12, 30, 0));
        dir_table.push_back(mk_row(255, 4, 4, 12, 30, 0));
        dir_table.push_back(mk_row(0, 0, 0, 10, 1023, 1));
        // wide region with bright pixels
        dir_table.push_back(mk_row(255, 0, 0, 200, 200, 0));
        dir_table.push_back(mk_row(255, 1, 1, 200, 200, 1, 1'b1, 200, 0, 0));
        // smaller row replaces, column spread too wide
        dir_table.push_back(mk_row(255, 3, 2, 8, 8, 0));
        dir_table.push_back(mk_row(255, 6, 1, 8, 8, 0));
        dir_table.push_back(mk_row(255, 2, 3, 8, 8, 1));

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        src_idle_pct = 14;
        sink_idle_pct = 83;
        foreach (dir_table[i])
            drive_pixel(dir_table[i].px, dir_table[i].typed, dir_table[i].want);

        for (int p = 0; p < 6; p++) begin
            settle();
            case (p)
                0: write_config(8'd255, 10'd1023);
                1: write_config(8'd0, 10'd0);
                2: write_config(LUMA_W'($urandom), DIM_W'($urandom));
                3: write_config(8'd128, DIM_W'($urandom_range(12, 2)));
                4: write_config(LUMA_W'($urandom), 10'd1023);
                default: write_config(BRIGHT_THRESHOLD_RST, DIM_W'($urandom_range(12, 0)));
            endcase
            case (p / 2)
                0: begin
                    src_idle_pct = 14;
                    sink_idle_pct = 83;
                end
                1: begin
                    src_idle_pct = 83;
                    sink_idle_pct = 14;
                end
                default: begin
                    src_idle_pct = 0;
                    sink_idle_pct = 0;
                end
            endcase
            phase_pixels = 0;
            phase_results = 0;
            while (phase_pixels < PHASE_PIXELS || phase_results < PHASE_HEIGHTS) begin
                pick = $urandom_range(99);
                if (pick < 65) begin
                    send_region();
                end else if (pick < 85) begin
                    send_fragment();
                end else begin
                    px = pixel_t'(PIX_W'({$urandom, $urandom}));
                    drive_pixel(px, 1'b0, '0);
                end
            end
        end
        settle();

        if (height_errors == 0 && pending_heights.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
